FILE: hw/rtl/binary_sequence_flip_lnds_tree_defines.svh
// Assertion macros used by the checker file of the range-flip tree block.
`ifndef BINARY_SEQUENCE_FLIP_LNDS_TREE_DEFINES_SVH
`define BINARY_SEQUENCE_FLIP_LNDS_TREE_DEFINES_SVH

// Property that must hold in the same cycle as its trigger
`define BSFT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Property that must hold in the cycle after its trigger
`define BSFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/bsft_pkg.sv
// Shared types, constants and summary functions of the range-flip tree.
`timescale 1ns / 1ps

package bsft_pkg;

  localparam int MAX_POSITIONS = 1024;
  localparam int TREE_LOG      = $clog2(MAX_POSITIONS);
  localparam int TREE_SIZE     = 1 << TREE_LOG;
  // node addresses run 1 .. 2*TREE_SIZE-1, root at 1, leaves at TREE_SIZE+pos
  localparam int NODE_AW       = TREE_LOG + 1;
  localparam int NODE_DEPTH    = 2 * TREE_SIZE;
  // walk indices must also hold 2*TREE_SIZE
  localparam int IDX_W         = NODE_AW + 1;
  localparam int LVL_W         = $clog2(TREE_LOG + 1);

  localparam int CNT_W  = 11;
  localparam int POS_W  = 10;
  localparam int RNG_W  = 11;
  localparam int KIND_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 2'd0,
    KIND_FLIP  = 2'd1,
    KIND_QUERY = 2'd2
  } kind_e;

  typedef struct packed {
    logic [CNT_W-1:0] zeros;
    logic [CNT_W-1:0] ones;
    logic [CNT_W-1:0] up;
    logic [CNT_W-1:0] down;
  } summ_t;

  // one memory word: pending flip mark plus node summary
  typedef struct packed {
    logic  lz;
    summ_t s;
  } node_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  left;
    logic [RNG_W-1:0]  right;
    logic              digit;
  } item_t;

  typedef struct packed {
    summ_t s;
    logic  err;
  } res_t;

  typedef struct packed {
    logic               re;
    logic [NODE_AW-1:0] raddr;
    logic               we;
    logic [NODE_AW-1:0] waddr;
    node_t              wdata;
  } ram_req_t;

  function automatic logic [CNT_W-1:0] cnt_max3(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b,
                                                logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // combine the summary of a left span with that of the span right after it
  function automatic summ_t summ_merge(summ_t a, summ_t b);
    summ_t s;
    s.zeros = a.zeros + b.zeros;
    s.ones  = a.ones + b.ones;
    s.up    = cnt_max3(a.up + b.ones, a.zeros + b.up, a.zeros + b.ones);
    s.down  = cnt_max3(a.down + b.zeros, a.ones + b.down, a.ones + b.zeros);
    return s;
  endfunction

  // inverting every digit swaps the counts pairwise
  function automatic summ_t summ_flip(summ_t a);
    summ_t s;
    s.zeros = a.ones;
    s.ones  = a.zeros;
    s.up    = a.down;
    s.down  = a.up;
    return s;
  endfunction

  function automatic summ_t summ_leaf(logic digit);
    summ_t s;
    s.zeros = digit ? '0 : CNT_W'(1);
    s.ones  = digit ? CNT_W'(1) : '0;
    s.up    = CNT_W'(1);
    s.down  = CNT_W'(1);
    return s;
  endfunction

endpackage

FILE: hw/rtl/bsft_node_ram.sv
// Node memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module bsft_node_ram (
  input  logic               clk_i,
  input  bsft_pkg::ram_req_t req_i,
  output bsft_pkg::node_t    rdata_o
);

  bsft_pkg::node_t mem_q [bsft_pkg::NODE_DEPTH];
  bsft_pkg::node_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/bsft_seq.sv
// Sequencer: clears the node memory, then runs pushes, the range walk and updates.
`timescale 1ns / 1ps

module bsft_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  bsft_pkg::item_t              item_i,
  input  logic [bsft_pkg::CNT_W-1:0]   used_i,
  output logic                         idle_o,
  output logic                         done_o,
  input  logic                         take_i,
  output bsft_pkg::res_t               res_o,
  output bsft_pkg::ram_req_t           ram_req_o,
  input  bsft_pkg::node_t              ram_rdata_i
);

  typedef enum logic [14:0] {
    S_CLEAR    = 15'b000000000000001,
    S_IDLE     = 15'b000000000000010,
    S_PLAN     = 15'b000000000000100,
    S_PUSH_RD  = 15'b000000000001000,
    S_PUSH_CHK = 15'b000000000010000,
    S_PUSH_C0  = 15'b000000000100000,
    S_PUSH_C1  = 15'b000000001000000,
    S_APPLY_RD = 15'b000000010000000,
    S_APPLY_WR = 15'b000000100000000,
    S_UPD_RD   = 15'b000001000000000,
    S_UPD_R2   = 15'b000010000000000,
    S_UPD_WR   = 15'b000100000000000,
    S_ACC_RD   = 15'b001000000000000,
    S_ACC_WR   = 15'b010000000000000,
    S_DONE     = 15'b100000000000000
  } state_e;

  typedef enum logic [3:0] {
    PH_PUSH = 4'b0001,
    PH_WALK = 4'b0010,
    PH_UPD  = 4'b0100,
    PH_END  = 4'b1000
  } phase_e;

  state_e                          state_q, state_d;
  phase_e                          ph_q, ph_d;
  logic [bsft_pkg::NODE_AW-1:0]    clr_q, clr_d;
  bsft_pkg::kind_e                 kind_q, kind_d;
  logic                            digit_q, digit_d;
  logic [bsft_pkg::IDX_W-1:0]      l0_q, l0_d, r0_q, r0_d;
  logic [bsft_pkg::IDX_W-1:0]      wl_q, wl_d, wr_q, wr_d;
  logic [bsft_pkg::LVL_W-1:0]      lvl_q, lvl_d;
  logic                            side_q, side_d;
  logic                            acc_right_q, acc_right_d;
  logic [bsft_pkg::NODE_AW-1:0]    k_q, k_d;
  bsft_pkg::summ_t                 accl_q, accl_d, accr_q, accr_d, tmp_q, tmp_d;
  bsft_pkg::res_t                  res_q, res_d;

  // start decode
  logic [bsft_pkg::RNG_W-1:0]      left_x;
  logic                            st_err, st_run;
  logic [bsft_pkg::IDX_W-1:0]      st_l0, st_r0;

  always_comb begin
    left_x = bsft_pkg::RNG_W'(item_i.left);
    st_l0  = bsft_pkg::IDX_W'(bsft_pkg::TREE_SIZE) + bsft_pkg::IDX_W'(item_i.left);
    st_r0  = bsft_pkg::IDX_W'(bsft_pkg::TREE_SIZE) + bsft_pkg::IDX_W'(item_i.right);
    st_err = 1'b0;
    st_run = 1'b0;
    case (item_i.kind)
      bsft_pkg::KIND_WRITE: begin
        st_err = (left_x >= used_i);
        st_run = !st_err;
        // a single digit is the one-wide range at its position
        st_r0  = st_l0 + bsft_pkg::IDX_W'(1);
      end
      bsft_pkg::KIND_FLIP, bsft_pkg::KIND_QUERY: begin
        st_err = (left_x > item_i.right) || (item_i.right > used_i);
        st_run = !st_err && (left_x != item_i.right);
      end
      default: begin
        st_err = 1'b0;
        st_run = 1'b0;
      end
    endcase
  end

  // boundary node at the current level, left or right side
  logic [bsft_pkg::IDX_W-1:0]      lo_mask, side_pos, side_base;
  logic                            lvl_cond;
  logic [bsft_pkg::NODE_AW-1:0]    lvl_node;

  always_comb begin
    lo_mask   = ~({bsft_pkg::IDX_W{1'b1}} << lvl_q);
    side_pos  = side_q ? r0_q : l0_q;
    side_base = side_q ? (r0_q - bsft_pkg::IDX_W'(1)) : l0_q;
    lvl_cond  = |(side_pos & lo_mask);
    lvl_node  = bsft_pkg::NODE_AW'(side_base >> lvl_q);
  end

  // children of the current node and whether they are internal
  logic [bsft_pkg::NODE_AW-1:0]    child0, child1;
  logic                            child_int, k_int;
  state_e                          walk_op;

  always_comb begin
    child0    = {k_q[bsft_pkg::NODE_AW-2:0], 1'b0};
    child1    = {k_q[bsft_pkg::NODE_AW-2:0], 1'b1};
    child_int = (k_q < bsft_pkg::NODE_AW'(bsft_pkg::TREE_SIZE / 2));
    k_int     = !k_q[bsft_pkg::NODE_AW-1];
    walk_op   = (kind_q == bsft_pkg::KIND_QUERY) ? S_ACC_RD : S_APPLY_RD;
  end

  // main sequencer; no entry is read in the cycle it is written
  always_comb begin
    logic [bsft_pkg::IDX_W-1:0] wr_n;
    state_d     = state_q;
    ph_d        = ph_q;
    clr_d       = clr_q;
    kind_d      = kind_q;
    digit_d     = digit_q;
    l0_d        = l0_q;
    r0_d        = r0_q;
    wl_d        = wl_q;
    wr_d        = wr_q;
    lvl_d       = lvl_q;
    side_d      = side_q;
    acc_right_d = acc_right_q;
    k_d         = k_q;
    accl_d      = accl_q;
    accr_d      = accr_q;
    tmp_d       = tmp_q;
    res_d       = res_q;
    ram_req_o   = '0;
    wr_n        = wr_q[0] ? (wr_q - bsft_pkg::IDX_W'(1)) : wr_q;

    case (state_q)
      S_CLEAR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = clr_q;
        ram_req_o.wdata = '0;
        clr_d           = clr_q + bsft_pkg::NODE_AW'(1);
        if (clr_q == {bsft_pkg::NODE_AW{1'b1}}) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start_i) begin
          kind_d    = bsft_pkg::kind_e'(item_i.kind);
          digit_d   = item_i.digit;
          l0_d      = st_l0;
          r0_d      = st_r0;
          ph_d      = PH_PUSH;
          lvl_d     = bsft_pkg::LVL_W'(bsft_pkg::TREE_LOG);
          side_d    = 1'b0;
          accl_d    = '0;
          accr_d    = '0;
          res_d     = '0;
          res_d.err = st_err;
          state_d   = st_run ? S_PLAN : S_DONE;
        end
      end

      S_PLAN: begin
        case (ph_q)
          // push pending flips down both boundary paths, root first
          PH_PUSH: begin
            side_d = !side_q;
            if (side_q) begin
              if (lvl_q == bsft_pkg::LVL_W'(1)) begin
                ph_d = PH_WALK;
                wl_d = l0_q;
                wr_d = r0_q;
              end else begin
                lvl_d = lvl_q - bsft_pkg::LVL_W'(1);
              end
            end
            if (lvl_cond) begin
              k_d     = lvl_node;
              state_d = S_PUSH_RD;
            end
          end

          // bottom-up walk over the covering nodes
          PH_WALK: begin
            if (wl_q < wr_q) begin
              side_d      = !side_q;
              acc_right_d = side_q;
              if (!side_q) begin
                if (wl_q[0]) begin
                  k_d     = bsft_pkg::NODE_AW'(wl_q);
                  wl_d    = wl_q + bsft_pkg::IDX_W'(1);
                  state_d = walk_op;
                end
              end else begin
                wl_d = wl_q >> 1;
                wr_d = wr_n >> 1;
                if (wr_q[0]) begin
                  k_d     = bsft_pkg::NODE_AW'(wr_n);
                  state_d = walk_op;
                end
              end
            end else if (kind_q == bsft_pkg::KIND_QUERY) begin
              res_d.s = bsft_pkg::summ_merge(accl_q, accr_q);
              state_d = S_DONE;
            end else begin
              ph_d   = PH_UPD;
              lvl_d  = bsft_pkg::LVL_W'(1);
              side_d = 1'b0;
            end
          end

          // rebuild ancestors of the boundaries, leaf side first
          PH_UPD: begin
            side_d = !side_q;
            if (side_q) begin
              if (lvl_q == bsft_pkg::LVL_W'(bsft_pkg::TREE_LOG)) begin
                ph_d = PH_END;
              end else begin
                lvl_d = lvl_q + bsft_pkg::LVL_W'(1);
              end
            end
            if (lvl_cond) begin
              k_d     = lvl_node;
              state_d = S_UPD_RD;
            end
          end

          PH_END: begin
            state_d = S_DONE;
          end

          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      S_PUSH_RD: begin
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = k_q;
        state_d         = S_PUSH_CHK;
      end

      S_PUSH_CHK: begin
        if (ram_rdata_i.lz) begin
          ram_req_o.we       = 1'b1;
          ram_req_o.waddr    = k_q;
          ram_req_o.wdata.lz = 1'b0;
          ram_req_o.wdata.s  = ram_rdata_i.s;
          ram_req_o.re       = 1'b1;
          ram_req_o.raddr    = child0;
          state_d            = S_PUSH_C0;
        end else begin
          state_d = S_PLAN;
        end
      end

      S_PUSH_C0: begin
        ram_req_o.we       = 1'b1;
        ram_req_o.waddr    = child0;
        ram_req_o.wdata.lz = ram_rdata_i.lz ^ child_int;
        ram_req_o.wdata.s  = bsft_pkg::summ_flip(ram_rdata_i.s);
        ram_req_o.re       = 1'b1;
        ram_req_o.raddr    = child1;
        state_d            = S_PUSH_C1;
      end

      S_PUSH_C1: begin
        ram_req_o.we       = 1'b1;
        ram_req_o.waddr    = child1;
        ram_req_o.wdata.lz = ram_rdata_i.lz ^ child_int;
        ram_req_o.wdata.s  = bsft_pkg::summ_flip(ram_rdata_i.s);
        state_d            = S_PLAN;
      end

      S_APPLY_RD: begin
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = k_q;
        state_d         = S_APPLY_WR;
      end

      S_APPLY_WR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = k_q;
        if (kind_q == bsft_pkg::KIND_WRITE) begin
          ram_req_o.wdata.lz = 1'b0;
          ram_req_o.wdata.s  = bsft_pkg::summ_leaf(digit_q);
        end else begin
          ram_req_o.wdata.lz = ram_rdata_i.lz ^ k_int;
          ram_req_o.wdata.s  = bsft_pkg::summ_flip(ram_rdata_i.s);
        end
        state_d = S_PLAN;
      end

      S_UPD_RD: begin
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = child0;
        state_d         = S_UPD_R2;
      end

      S_UPD_R2: begin
        tmp_d           = ram_rdata_i.s;
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = child1;
        state_d         = S_UPD_WR;
      end

      S_UPD_WR: begin
        ram_req_o.we       = 1'b1;
        ram_req_o.waddr    = k_q;
        ram_req_o.wdata.lz = 1'b0;
        ram_req_o.wdata.s  = bsft_pkg::summ_merge(tmp_q, ram_rdata_i.s);
        state_d            = S_PLAN;
      end

      S_ACC_RD: begin
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = k_q;
        state_d         = S_ACC_WR;
      end

      S_ACC_WR: begin
        if (acc_right_q) begin
          accr_d = bsft_pkg::summ_merge(ram_rdata_i.s, accr_q);
        end else begin
          accl_d = bsft_pkg::summ_merge(accl_q, ram_rdata_i.s);
        end
        state_d = S_PLAN;
      end

      S_DONE: begin
        if (take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    ph_q        <= ph_d;
    kind_q      <= kind_d;
    digit_q     <= digit_d;
    l0_q        <= l0_d;
    r0_q        <= r0_d;
    wl_q        <= wl_d;
    wr_q        <= wr_d;
    lvl_q       <= lvl_d;
    side_q      <= side_d;
    acc_right_q <= acc_right_d;
    k_q         <= k_d;
    accl_q      <= accl_d;
    accr_q      <= accr_d;
    tmp_q       <= tmp_d;
    res_q       <= res_d;
  end

  assign idle_o = (state_q == S_IDLE);
  assign done_o = (state_q == S_DONE);
  assign res_o  = res_q;

endmodule

FILE: hw/rtl/binary_sequence_flip_lnds_tree.sv
// Top level of the range-flip binary sequence tree.
`timescale 1ns / 1ps

// Binary digit sequence held in a lazy segment tree with range flip. An item
// writes one digit, flips a range [left, right) or queries a range for its
// zero and one counts and its longest non-decreasing and non-increasing
// subsequences. Items run one at a time, paced by the single read port of
// the node memory: a pending-flip push along the two boundary paths reads
// the node and then its children, a covering node in the walk is read and
// then updated or accumulated, and an ancestor rebuild reads both children
// in turn before it writes. Items with a range error, kind 3 or an empty range
// go straight to done. After reset a clearing pass zeroes the node memory,
// during which no item is taken; configuration writes are taken at any time.
// A finished result waits in an output register while the next item is accepted.
module binary_sequence_flip_lnds_tree (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [bsft_pkg::KIND_W-1:0] kind_i,
  input  logic [bsft_pkg::POS_W-1:0]  left_i,
  input  logic [bsft_pkg::RNG_W-1:0]  right_i,
  input  logic                        digit_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bsft_pkg::CNT_W-1:0]  zeros_count_o,
  output logic [bsft_pkg::CNT_W-1:0]  ones_count_o,
  output logic [bsft_pkg::CNT_W-1:0]  longest_nondecreasing_o,
  output logic [bsft_pkg::CNT_W-1:0]  longest_nonincreasing_o,
  output logic                        range_error_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bsft_pkg::CNT_W-1:0]  cfg_data_i
);

  logic [bsft_pkg::CNT_W-1:0] length_q, length_d;
  logic [bsft_pkg::CNT_W-1:0] used;
  bsft_pkg::item_t            item;
  bsft_pkg::res_t             seq_res;
  bsft_pkg::res_t             out_q, out_d;
  logic                       out_valid_q, out_valid_d;
  logic                       seq_idle, seq_done, take, start;
  bsft_pkg::ram_req_t         ram_req;
  bsft_pkg::node_t            ram_rdata;

  // length register
  assign cfg_ready_o = 1'b1;
  assign length_d    = cfg_valid_i ? cfg_data_i : length_q;
  assign used        = (length_q > bsft_pkg::CNT_W'(bsft_pkg::MAX_POSITIONS))
                       ? bsft_pkg::CNT_W'(bsft_pkg::MAX_POSITIONS) : length_q;

  // input item
  assign in_stall_o = !seq_idle;
  assign start      = in_valid_i && !in_stall_o;
  always_comb begin
    item.kind  = kind_i;
    item.left  = left_i;
    item.right = right_i;
    item.digit = digit_i;
  end

  // output register
  assign take        = !out_valid_q || !out_stall_i;
  assign out_valid_d = (seq_done && take) || (out_valid_q && out_stall_i);
  assign out_d       = (seq_done && take) ? seq_res : out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q    <= bsft_pkg::CNT_W'(1024);
      out_valid_q <= 1'b0;
    end else begin
      length_q    <= length_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o             = out_valid_q;
  assign zeros_count_o           = out_q.s.zeros;
  assign ones_count_o            = out_q.s.ones;
  assign longest_nondecreasing_o = out_q.s.up;
  assign longest_nonincreasing_o = out_q.s.down;
  assign range_error_o           = out_q.err;

  bsft_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .item_i      (item),
    .used_i      (used),
    .idle_o      (seq_idle),
    .done_o      (seq_done),
    .take_i      (take),
    .res_o       (seq_res),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  bsft_node_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

endmodule

FILE: hw/rtl/bsft_checker.sv
// Port-level checks of the range-flip tree, bound to the top level.
`timescale 1ns / 1ps
`include "binary_sequence_flip_lnds_tree_defines.svh"

module bsft_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [bsft_pkg::CNT_W-1:0]  zeros_count_o,
  input logic [bsft_pkg::CNT_W-1:0]  ones_count_o,
  input logic [bsft_pkg::CNT_W-1:0]  longest_nondecreasing_o,
  input logic [bsft_pkg::CNT_W-1:0]  longest_nonincreasing_o,
  input logic                        range_error_o
);

  // a held result keeps its payload
  `BSFT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(zeros_count_o) && $stable(ones_count_o) && $stable(longest_nondecreasing_o) && $stable(longest_nonincreasing_o) && $stable(range_error_o), "stalled result changed")

  // items are taken one at a time
  `BSFT_ASSERT_NEXT(a_one_item, in_valid_i && !in_stall_o, in_stall_o, "second item taken while busy")

  // a rejected item reports no counts
  `BSFT_ASSERT_NOW(a_err_clean, out_valid_o && range_error_o, zeros_count_o == '0 && ones_count_o == '0 && longest_nondecreasing_o == '0 && longest_nonincreasing_o == '0, "error result carries counts")

  // a monotone run is at least as long as either digit count
  `BSFT_ASSERT_NOW(a_run_bounds, out_valid_o, longest_nondecreasing_o >= zeros_count_o && longest_nondecreasing_o >= ones_count_o && longest_nonincreasing_o >= zeros_count_o && longest_nonincreasing_o >= ones_count_o, "run shorter than digit count")

endmodule

bind binary_sequence_flip_lnds_tree bsft_checker u_bsft_checker (.*);
